// File: hw/rtl/coverage_shrink_detector_defines.svh
// Assertion helpers for the coverage shrink detector.
// Each macro expects clk and rst_n in scope.
`ifndef COVERAGE_SHRINK_DETECTOR_DEFINES_SVH
`define COVERAGE_SHRINK_DETECTOR_DEFINES_SVH

// Same-cycle implication.
`define CSD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/csd_pkg.sv
`timescale 1ns / 1ps

package csd_pkg;

    localparam int MAP_WORDS  = 8192;
    localparam int NUM_MAPS   = 3;
    localparam int MEM_DEPTH  = NUM_MAPS * MAP_WORDS;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);
    localparam int BYTE_W     = 8;
    localparam int LANES      = 8;
    localparam int WORD_W     = LANES * BYTE_W;
    localparam int IDX_W      = 13;
    localparam int SEL_W      = 2;
    localparam int HIT_W      = 64;
    localparam int CNT_W      = 17;
    localparam int STATUS_W   = 3;
    localparam int LANE_CNT_W = $clog2(LANES + 1);

    localparam logic [BYTE_W-1:0] BYTE_FULL = 8'hff;

    // Merge result of a first run.
    typedef enum logic [1:0] {
        DISC_NONE   = 2'd0,
        DISC_COUNTS = 2'd1,
        DISC_NEW    = 2'd2
    } disc_t;

    // What one byte lane finds.
    typedef struct packed {
        logic              nonzero;
        logic              overlap;
        logic              ref_full;
        logic              shrink;
        logic              fresh;
        logic [BYTE_W-1:0] shrunk_byte;
        logic [BYTE_W-1:0] merged_byte;
    } lane_t;

    // Word-level summary from the merge stage.
    typedef struct packed {
        logic [LANE_CNT_W-1:0] cnt;
        logic                  overlap;
        logic                  all_ones;
        logic                  mask_any;
        logic                  disc_any;
        logic [WORD_W-1:0]     shrunk;
        logic [WORD_W-1:0]     merged;
    } word_sum_t;

endpackage

// File: hw/rtl/csd_if.sv
`timescale 1ns / 1ps

interface csd_in_if;
    logic                         valid;
    logic                         ready;
    logic [csd_pkg::WORD_W-1:0]   trace_word;
    logic [csd_pkg::IDX_W-1:0]    word_index;
    logic [csd_pkg::SEL_W-1:0]    map_select;
    logic [csd_pkg::HIT_W-1:0]    hit_sum;
    logic                         last_word;

    modport source (
        output valid, trace_word, word_index, map_select, hit_sum, last_word,
        input  ready
    );
    modport sink (
        input  valid, trace_word, word_index, map_select, hit_sum, last_word,
        output ready
    );
endinterface

interface csd_out_if;
    logic                         valid;
    logic                         ready;
    logic [csd_pkg::STATUS_W-1:0] status;
    logic                         map_changed;
    logic [csd_pkg::CNT_W-1:0]    nonzero_bytes;
    logic                         first_run;

    modport source (
        output valid, status, map_changed, nonzero_bytes, first_run,
        input  ready
    );
    modport sink (
        input  valid, status, map_changed, nonzero_bytes, first_run,
        output ready
    );
endinterface

// File: hw/rtl/csd_lane.sv
`timescale 1ns / 1ps

module csd_lane (
    input  logic [csd_pkg::BYTE_W-1:0] trace_byte,
    input  logic [csd_pkg::BYTE_W-1:0] ref_byte,
    output csd_pkg::lane_t             res
);

    logic tb_zero;
    logic rb_full;

    assign tb_zero = (trace_byte == '0);
    assign rb_full = (ref_byte == csd_pkg::BYTE_FULL);

    always_comb
    begin
        res.nonzero     = !tb_zero;
        res.overlap     = |(trace_byte & ref_byte);
        res.ref_full    = rb_full;
        res.shrink      = !rb_full && tb_zero;
        res.fresh       = !tb_zero && rb_full;
        // restore untouched bytes to the empty pattern
        res.shrunk_byte = (!rb_full && tb_zero) ? csd_pkg::BYTE_FULL : ref_byte;
        res.merged_byte = ref_byte & ~trace_byte;
    end

endmodule

// File: hw/rtl/csd_merge.sv
`timescale 1ns / 1ps

module csd_merge (
    input  csd_pkg::lane_t     lanes [csd_pkg::LANES],
    output csd_pkg::word_sum_t sum
);

    always_comb
    begin
        sum.cnt      = '0;
        sum.overlap  = 1'b0;
        sum.all_ones = 1'b1;
        sum.mask_any = 1'b0;
        sum.disc_any = 1'b0;
        sum.shrunk   = '0;
        sum.merged   = '0;
        for (int i = 0; i < csd_pkg::LANES; i++)
        begin
            sum.cnt      = sum.cnt + csd_pkg::LANE_CNT_W'(lanes[i].nonzero);
            sum.overlap  = sum.overlap  | lanes[i].overlap;
            sum.all_ones = sum.all_ones & lanes[i].ref_full;
            sum.mask_any = sum.mask_any | lanes[i].shrink;
            sum.disc_any = sum.disc_any | lanes[i].fresh;
            sum.shrunk[i*csd_pkg::BYTE_W +: csd_pkg::BYTE_W] = lanes[i].shrunk_byte;
            sum.merged[i*csd_pkg::BYTE_W +: csd_pkg::BYTE_W] = lanes[i].merged_byte;
        end
    end

endmodule

// File: hw/rtl/coverage_shrink_detector.sv
// Result path: the last word is registered in the compare stage, then its result in the output register.
// Throughput: one trace word per cycle unless an untaken result stalls the last word; eight byte lanes
// handle a word at once, and the reference map does one read and one write-back per cycle.
// Reset: control state clears at once, then a sweep fills every reference map entry
// with all ones; no word is accepted during it.
`timescale 1ns / 1ps
`include "coverage_shrink_detector_defines.svh"

module coverage_shrink_detector (
    input  logic             clk,
    input  logic             rst_n,
    csd_in_if.sink           trace,
    csd_out_if.source        result
);

    // reference map storage
    logic [csd_pkg::WORD_W-1:0] mem [csd_pkg::MEM_DEPTH];
    logic [csd_pkg::WORD_W-1:0] rd_data_reg;
    logic [csd_pkg::MEM_AW-1:0] rd_addr;
    logic                       rd_en;
    logic                       mem_we;
    logic [csd_pkg::MEM_AW-1:0] mem_waddr;
    logic [csd_pkg::WORD_W-1:0] mem_wdata;

    // clearing sweep
    logic                       clr_busy_reg;
    logic [csd_pkg::MEM_AW-1:0] clr_addr_reg;

    // write-back forwarding
    logic                       wb_valid_reg;
    logic [csd_pkg::MEM_AW-1:0] wb_addr_reg;
    logic [csd_pkg::WORD_W-1:0] wb_data_reg;

    // compare stage
    logic                       s1_valid_reg;
    logic [csd_pkg::WORD_W-1:0] s1_trace_reg;
    logic [csd_pkg::SEL_W-1:0]  s1_sel_reg;
    logic [csd_pkg::HIT_W-1:0]  s1_hits_reg;
    logic                       s1_last_reg;
    logic                       s1_ok_reg;
    logic [csd_pkg::MEM_AW-1:0] s1_addr_reg;
    logic                       s1_adv;
    logic                       s1_fire;
    logic                       in_fire;
    logic                       in_ok;

    // run state
    logic                       run_open_reg;
    logic                       init_reg;
    logic [csd_pkg::CNT_W-1:0]  min_byte_reg;
    logic [csd_pkg::HIT_W-1:0]  min_hit_reg;
    logic [csd_pkg::CNT_W-1:0]  acc_reg;
    logic                       hit_reg;
    logic                       cov_reg;
    csd_pkg::disc_t             disc_reg;
    logic                       main_reg;

    // output register
    logic                         out_valid_reg;
    logic [csd_pkg::STATUS_W-1:0] out_status_reg;
    logic                         out_changed_reg;
    logic [csd_pkg::CNT_W-1:0]    out_nz_reg;
    logic                         out_first_reg;
    logic                         out_free;

    // datapath
    logic [csd_pkg::WORD_W-1:0] ref_word;
    csd_pkg::lane_t             lane_res [csd_pkg::LANES];
    csd_pkg::word_sum_t         wsum;

    logic                         run_start;
    logic                         init_now;
    logic                         init_eff;
    logic [csd_pkg::HIT_W-1:0]    min_hit_eff;
    logic [csd_pkg::CNT_W-1:0]    acc_base;
    logic [csd_pkg::CNT_W:0]      acc_sum;
    logic [csd_pkg::CNT_W-1:0]    acc_next;
    logic                         hit_next;
    logic                         cov_next;
    csd_pkg::disc_t               disc_base;
    csd_pkg::disc_t               disc_next;
    logic                         main_next;
    logic [csd_pkg::HIT_W-1:0]    min_hit_next;
    logic [csd_pkg::CNT_W-1:0]    min_byte_next;
    logic [csd_pkg::WORD_W-1:0]   wr_data;
    logic                         size_drop;
    logic [csd_pkg::STATUS_W-1:0] status_next;
    logic                         changed_next;

    assign out_free = !out_valid_reg || result.ready;
    assign s1_adv   = !s1_valid_reg || !s1_last_reg || out_free;
    assign s1_fire  = s1_valid_reg && s1_adv;

    assign trace.ready = !clr_busy_reg && s1_adv;
    assign in_fire     = trace.valid && trace.ready;
    assign in_ok       = (int'(trace.map_select) < csd_pkg::NUM_MAPS)
                      && (int'(trace.word_index) < csd_pkg::MAP_WORDS);

    assign rd_en   = in_fire;
    assign rd_addr = in_ok
        ? csd_pkg::MEM_AW'(int'(trace.map_select) * csd_pkg::MAP_WORDS
                           + int'(trace.word_index))
        : '0;

    assign mem_we    = clr_busy_reg || (s1_fire && s1_ok_reg);
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : s1_addr_reg;
    assign mem_wdata = clr_busy_reg ? '1 : wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == csd_pkg::MEM_AW'(csd_pkg::MEM_DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // latest write wins over the registered read
    assign ref_word = (wb_valid_reg && wb_addr_reg == s1_addr_reg) ? wb_data_reg : rd_data_reg;

    for (genvar g = 0; g < csd_pkg::LANES; g++)
    begin : g_lane
        csd_lane u_lane (
            .trace_byte (s1_trace_reg[g*csd_pkg::BYTE_W +: csd_pkg::BYTE_W]),
            .ref_byte   (ref_word[g*csd_pkg::BYTE_W +: csd_pkg::BYTE_W]),
            .res        (lane_res[g])
        );
    end

    csd_merge u_merge (
        .lanes (lane_res),
        .sum   (wsum)
    );

    always_comb
    begin
        run_start   = !run_open_reg;
        init_now    = (min_byte_reg == '0) && (min_hit_reg == '1);
        init_eff    = run_start ? init_now : init_reg;
        min_hit_eff = (run_start && init_now) ? s1_hits_reg : min_hit_reg;
        acc_base    = run_start ? '0 : acc_reg;
        hit_next    = run_start ? 1'b0 : hit_reg;
        cov_next    = run_start ? 1'b0 : cov_reg;
        disc_base   = run_start ? csd_pkg::DISC_NONE : disc_reg;
        disc_next   = disc_base;
        main_next   = run_start ? 1'b0 : main_reg;
        min_hit_next = min_hit_eff;
        wr_data     = ref_word;
        acc_sum     = {1'b0, acc_base} + (csd_pkg::CNT_W + 1)'(wsum.cnt);
        acc_next    = acc_base;

        if (s1_ok_reg)
        begin
            // saturate the byte count
            acc_next = acc_sum[csd_pkg::CNT_W] ? '1 : acc_sum[csd_pkg::CNT_W-1:0];
            if (init_eff)
            begin
                if (wsum.overlap)
                begin
                    if (disc_base != csd_pkg::DISC_NEW)
                    begin
                        disc_next = wsum.disc_any ? csd_pkg::DISC_NEW : csd_pkg::DISC_COUNTS;
                    end
                    wr_data = wsum.merged;
                    if (s1_sel_reg == '0)
                    begin
                        main_next = 1'b1;
                    end
                end
            end
            else if (!wsum.all_ones && wsum.overlap)
            begin
                if (wsum.mask_any)
                begin
                    wr_data  = wsum.shrunk;
                    cov_next = 1'b1;
                end
                if (s1_hits_reg < min_hit_eff)
                begin
                    min_hit_next = s1_hits_reg;
                    hit_next     = 1'b1;
                end
            end
        end

        size_drop     = !init_eff && (min_byte_reg != '0) && (acc_next < min_byte_reg);
        min_byte_next = min_byte_reg;
        if (s1_last_reg && (init_eff || size_drop))
        begin
            min_byte_next = acc_next;
        end
        status_next  = init_eff ? {1'b0, disc_next} : {size_drop, cov_next, hit_next};
        changed_next = init_eff ? main_next : cov_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            wb_valid_reg  <= 1'b0;
            run_open_reg  <= 1'b0;
            init_reg      <= 1'b0;
            min_byte_reg  <= '0;
            min_hit_reg   <= '1;
            acc_reg       <= '0;
            hit_reg       <= 1'b0;
            cov_reg       <= 1'b0;
            disc_reg      <= csd_pkg::DISC_NONE;
            main_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= in_fire;
            end
            if (s1_fire)
            begin
                run_open_reg <= !s1_last_reg;
                init_reg     <= init_eff;
                min_byte_reg <= min_byte_next;
                min_hit_reg  <= min_hit_next;
                acc_reg      <= acc_next;
                hit_reg      <= hit_next;
                cov_reg      <= cov_next;
                disc_reg     <= disc_next;
                main_reg     <= main_next;
                if (s1_ok_reg)
                begin
                    wb_valid_reg <= 1'b1;
                end
            end
            if (s1_fire && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_trace_reg <= trace.trace_word;
            s1_sel_reg   <= trace.map_select;
            s1_hits_reg  <= trace.hit_sum;
            s1_last_reg  <= trace.last_word;
            s1_ok_reg    <= in_ok;
            s1_addr_reg  <= rd_addr;
        end
        if (s1_fire && s1_ok_reg)
        begin
            wb_addr_reg <= s1_addr_reg;
            wb_data_reg <= wr_data;
        end
        if (s1_fire && s1_last_reg)
        begin
            out_status_reg  <= status_next;
            out_changed_reg <= changed_next;
            out_nz_reg      <= acc_next;
            out_first_reg   <= init_eff;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = out_status_reg;
    assign result.map_changed   = out_changed_reg;
    assign result.nonzero_bytes = out_nz_reg;
    assign result.first_run     = out_first_reg;

    `CSD_ASSERT_IMPL(a_no_accept_in_clear, clr_busy_reg, !(trace.valid && trace.ready), "word accepted during map clear")
    `CSD_ASSERT_NEXT(a_last_gives_result, s1_fire && s1_last_reg, out_valid_reg, "last word gave no result")
    `CSD_ASSERT_NEXT(a_first_run_min, s1_fire && s1_last_reg && init_eff, min_byte_reg == out_nz_reg, "first run did not keep byte count")
    `CSD_ASSERT_NEXT(a_min_hit_falls, !(s1_fire && run_start && init_now), min_hit_reg <= $past(min_hit_reg), "hit minimum rose")

endmodule
